/* design/apw_pkg.sv */
// Shared types and constants for the 2-D average pooling window block.
// Holds register codes and reset values, the configuration struct, the controller
// states, and the command/status structs. Depends on nothing.
package apw_pkg;

  // Signed window coordinate width: row*stride (10 bits) plus kernel offset and sign
  localparam int POS_W = 12;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [6:0] RST_PLANE_HEIGHT = 7'd64;
  localparam logic [6:0] RST_PLANE_WIDTH = 7'd64;
  localparam logic [3:0] RST_KERNEL_ROWS = 4'd2;
  localparam logic [3:0] RST_KERNEL_COLS = 4'd2;
  localparam logic [3:0] RST_STEP_ROWS = 4'd2;
  localparam logic [3:0] RST_STEP_COLS = 4'd2;
  localparam logic [2:0] RST_BORDER_ROWS = 3'd0;
  localparam logic [2:0] RST_BORDER_COLS = 3'd0;

  typedef enum logic [2:0] {
    REG_PLANE_HEIGHT = 3'd0,
    REG_PLANE_WIDTH  = 3'd1,
    REG_KERNEL_ROWS  = 3'd2,
    REG_KERNEL_COLS  = 3'd3,
    REG_STEP_ROWS    = 3'd4,
    REG_STEP_COLS    = 3'd5,
    REG_BORDER_ROWS  = 3'd6,
    REG_BORDER_COLS  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] plane_height;
    logic [6:0] plane_width;
    logic [3:0] kernel_rows;
    logic [3:0] kernel_cols;
    logic [3:0] step_rows;
    logic [3:0] step_cols;
    logic [2:0] border_rows;
    logic [2:0] border_cols;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_DRAIN  = 3'd2,
    ST_DIVIDE = 3'd3,
    ST_DONE   = 3'd4
  } state_t;

  typedef struct packed {
    logic load;      // write the beat's sample at the load address
    logic capture;   // latch a query's window origin, clear counters and sum
    logic issue;     // read one window position
    logic div_load;  // start the divide from the finished sum
    logic div_step;  // one quotient bit
    logic out_load;  // move the quotient into the output register
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // the position being issued is the last of the window
    logic pipe_busy;  // reads still in flight toward the accumulator
    logic div_last;   // this divide step produces the last quotient bit
  } status_t;

endpackage

/* design/apw_ctrl.sv */
// Controller state machine for the average pooling block.
// Sequences load, window scan, drain, divide and hand-off. Depends on apw_pkg.
module apw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              kind,
  input  logic              out_free,
  input  apw_pkg::status_t  status,
  output logic              s_tready,
  output apw_pkg::cmd_t     cmd
);

  apw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      apw_pkg::ST_IDLE: begin
        if (s_tvalid && kind) begin
          state_next = apw_pkg::ST_SCAN;
        end
      end
      apw_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = apw_pkg::ST_DRAIN;
        end
      end
      apw_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = apw_pkg::ST_DIVIDE;
        end
      end
      apw_pkg::ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = apw_pkg::ST_DONE;
        end
      end
      apw_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = apw_pkg::ST_IDLE;
        end
      end
      default: state_next = apw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd = '0;
    case (state)
      apw_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid && !kind;
        cmd.capture = s_tvalid && kind;
      end
      apw_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      apw_pkg::ST_DRAIN: begin
        cmd.div_load = !status.pipe_busy;
      end
      apw_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      apw_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

/* design/apw_datapath.sv */
// Datapath for the average pooling block: plane memory, load address, window
// address generation, read pipeline, accumulator and serial floored divider.
// Depends on apw_pkg.
module apw_datapath #(
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apw_pkg::cfg_t                     cfg,
  input  apw_pkg::cmd_t                     cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [apw_pkg::ROW_W-1:0]         out_row,
  input  logic [apw_pkg::COL_W-1:0]         out_col,
  output apw_pkg::status_t                  status,
  output logic signed [SAMPLE_BITS-1:0]     average
);

  localparam int HT_W = $clog2(MAX_HEIGHT + 1);
  localparam int WD_W = $clog2(MAX_WIDTH + 1);
  localparam int RI_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CI_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KE_W = $clog2(MAX_KERNEL + 1);
  localparam int AREA_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int NUM_W = SUM_W - 1;
  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam int PA_W = HT_W + WD_W;
  localparam int RB_W = RI_W + WD_W;
  localparam int POS_W = apw_pkg::POS_W;

  // Effective configuration
  logic [HT_W-1:0]   h_eff;
  logic [WD_W-1:0]   w_eff;
  logic [KE_W-1:0]   kr_eff;
  logic [KE_W-1:0]   kc_eff;
  logic [3:0]        sr_eff;
  logic [3:0]        sc_eff;
  logic [AREA_W-1:0] area_k;
  logic [PA_W-1:0]   plane_area;

  always_comb begin
    if (cfg.plane_height == '0) begin
      h_eff = HT_W'(1);
    end else if (32'(cfg.plane_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HT_W'(cfg.plane_height);
    end
    if (cfg.plane_width == '0) begin
      w_eff = WD_W'(1);
    end else if (32'(cfg.plane_width) > 32'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = WD_W'(cfg.plane_width);
    end
    if (cfg.kernel_rows == '0) begin
      kr_eff = KE_W'(1);
    end else if (32'(cfg.kernel_rows) > 32'(MAX_KERNEL)) begin
      kr_eff = KE_W'(MAX_KERNEL);
    end else begin
      kr_eff = KE_W'(cfg.kernel_rows);
    end
    if (cfg.kernel_cols == '0) begin
      kc_eff = KE_W'(1);
    end else if (32'(cfg.kernel_cols) > 32'(MAX_KERNEL)) begin
      kc_eff = KE_W'(MAX_KERNEL);
    end else begin
      kc_eff = KE_W'(cfg.kernel_cols);
    end
    sr_eff = (cfg.step_rows == '0) ? 4'd1 : cfg.step_rows;
    sc_eff = (cfg.step_cols == '0) ? 4'd1 : cfg.step_cols;
    area_k = AREA_W'(kr_eff) * AREA_W'(kc_eff);
    plane_area = PA_W'(h_eff) * PA_W'(w_eff);
  end

  // Plane memory and load address
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]      load_address;
  logic [ADDR_W-1:0]      load_address_next;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W:0]        wr_succ;

  always_comb begin
    // wrap first if the plane shrank under the current address
    if (32'(load_address) >= 32'(plane_area)) begin
      wr_addr = '0;
    end else begin
      wr_addr = load_address;
    end
    wr_succ = {1'b0, wr_addr} + (ADDR_W + 1)'(1);
    if (32'(wr_succ) >= 32'(plane_area)) begin
      load_address_next = '0;
    end else begin
      load_address_next = wr_succ[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= '0;
    end else if (cmd.load) begin
      load_address <= load_address_next;
    end
  end

  // Window origin and scan counters
  logic [9:0]              row_prod;
  logic [9:0]              col_prod;
  logic signed [POS_W-1:0] r0, r0_next;
  logic signed [POS_W-1:0] c0, c0_next;
  logic [KE_W-1:0]         n_idx;
  logic [KE_W-1:0]         m_idx;
  logic signed [POS_W-1:0] r_pos;
  logic signed [POS_W-1:0] c_pos;
  logic                    r_in;
  logic                    c_in;
  logic [RB_W-1:0]         row_base;
  logic [RB_W-1:0]         addr_sum;
  logic [ADDR_W-1:0]       addr_calc;
  logic                    m_last;

  always_comb begin
    row_prod = 10'(out_row) * 10'(sr_eff);
    col_prod = 10'(out_col) * 10'(sc_eff);
    r0_next = $signed(POS_W'(row_prod)) - $signed(POS_W'(cfg.border_rows));
    c0_next = $signed(POS_W'(col_prod)) - $signed(POS_W'(cfg.border_cols));
    r_pos = r0 + $signed(POS_W'(n_idx));
    c_pos = c0 + $signed(POS_W'(m_idx));
    r_in = (r_pos >= 0) && (r_pos < $signed(POS_W'(h_eff)));
    c_in = (c_pos >= 0) && (c_pos < $signed(POS_W'(w_eff)));
    row_base = RB_W'(r_pos[RI_W-1:0]) * RB_W'(w_eff);
    addr_sum = row_base + RB_W'(c_pos[CI_W-1:0]);
    addr_calc = ADDR_W'(addr_sum);
    m_last = (m_idx == kc_eff - KE_W'(1));
  end

  assign status.scan_last = m_last && (n_idx == kr_eff - KE_W'(1));

  // Read pipeline and accumulator
  logic [ADDR_W-1:0]             addr_q;
  logic                          inb_q;
  logic                          addr_v;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          inb_r;
  logic                          read_v;
  logic signed [SUM_W-1:0]       sum;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_addr] <= sample;
    end
    rd_data <= $signed(mem[addr_q]);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r0 <= r0_next;
      c0 <= c0_next;
    end
    addr_q <= addr_calc;
    inb_q <= r_in && c_in;
    inb_r <= inb_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_idx <= '0;
      m_idx <= '0;
      addr_v <= 1'b0;
      read_v <= 1'b0;
      sum <= '0;
    end else begin
      addr_v <= cmd.issue;
      read_v <= addr_v;
      if (cmd.capture) begin
        n_idx <= '0;
        m_idx <= '0;
        sum <= '0;
      end else begin
        if (cmd.issue) begin
          if (m_last) begin
            m_idx <= '0;
            n_idx <= n_idx + KE_W'(1);
          end else begin
            m_idx <= m_idx + KE_W'(1);
          end
        end
        // positions outside the plane add zero
        if (read_v && inb_r) begin
          sum <= sum + SUM_W'(rd_data);
        end
      end
    end
  end

  assign status.pipe_busy = addr_v || read_v;

  // Serial restoring divider: floor(s/d) = ~floor(~s/d) for negative s
  logic              neg;
  logic [NUM_W-1:0]  quo;
  logic [AREA_W-1:0] rem;
  logic [CNT_W-1:0]  dcnt;
  logic [AREA_W:0]   trial;
  logic [AREA_W:0]   trial_diff;
  logic [SAMPLE_BITS-1:0] res_mag;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    trial_diff = trial - {1'b0, area_k};
    res_mag = SAMPLE_BITS'(quo);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg <= sum[SUM_W-1];
      quo <= sum[SUM_W-1] ? ~sum[NUM_W-1:0] : sum[NUM_W-1:0];
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, area_k}) begin
        rem <= AREA_W'(trial_diff);
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[AREA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      dcnt <= dcnt + CNT_W'(1);
    end
  end

  assign status.div_last = (dcnt == CNT_W'(NUM_W - 1));
  assign average = neg ? $signed(~res_mag) : $signed(res_mag);

endmodule

/* design/avg_pool_2d_window.sv */
// Top level of the 2-D average pooling window block (padding counted as zero).
// Holds the APB register file, the output register, and joins apw_ctrl and
// apw_datapath. Depends on apw_pkg, apw_ctrl, apw_datapath.
//
//   channel   dir   handshake                  beat contents
//   s_*       in    s_tvalid / s_tready        tuser: kind; tdata: sample, out_row, out_col
//   m_*       out   m_tvalid / m_tready        tdata: average
//   APB       in    psel & penable & pwrite    8 registers at byte address 4*index
//
// A load beat writes its sample to the plane memory when accepted. A query runs a capture
// step, one plane read per window position through the single memory read port, a drain
// of the read pipeline and the divider load, one quotient bit per cycle over a NUM_W-bit
// quotient, where NUM_W = SAMPLE_BITS + log2(MAX_KERNEL^2) - 1 (21 by default), and one
// hand-off.
// The finished result waits in the output register, so loads and the next query proceed
// while m_tready is low; a query only stalls at hand-off if the previous result is
// still held. Reset is synchronous and clears control state only; the plane memory
// is not cleared and holds undefined data until loaded.
module avg_pool_2d_window #(
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata: sample [SAMPLE_BITS-1:0], out_row [+5:+0], out_col [+11:+6], zero pad
  input  logic [((SAMPLE_BITS+12+7)/8)*8-1:0] s_tdata,
  // tuser: kind (0 load, 1 query)
  input  logic                               s_tuser,
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata: average [SAMPLE_BITS-1:0], zero pad
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [apw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [apw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [apw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ROW_LO = SAMPLE_BITS;
  localparam int COL_LO = SAMPLE_BITS + apw_pkg::ROW_W;

  apw_pkg::cfg_t    cfg;
  apw_pkg::cmd_t    cmd;
  apw_pkg::status_t status;
  apw_pkg::reg_idx_t reg_sel;

  logic                          cfg_wr;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] result;
  logic signed [SAMPLE_BITS-1:0] average;

  // ---------------------------------------------------------------------------
  // Register file: write on the access phase, read back any time
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_sel = apw_pkg::reg_idx_t'(paddr[apw_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_height <= apw_pkg::RST_PLANE_HEIGHT;
      cfg.plane_width <= apw_pkg::RST_PLANE_WIDTH;
      cfg.kernel_rows <= apw_pkg::RST_KERNEL_ROWS;
      cfg.kernel_cols <= apw_pkg::RST_KERNEL_COLS;
      cfg.step_rows <= apw_pkg::RST_STEP_ROWS;
      cfg.step_cols <= apw_pkg::RST_STEP_COLS;
      cfg.border_rows <= apw_pkg::RST_BORDER_ROWS;
      cfg.border_cols <= apw_pkg::RST_BORDER_COLS;
    end else if (cfg_wr) begin
      case (reg_sel)
        apw_pkg::REG_PLANE_HEIGHT: cfg.plane_height <= pwdata[6:0];
        apw_pkg::REG_PLANE_WIDTH:  cfg.plane_width <= pwdata[6:0];
        apw_pkg::REG_KERNEL_ROWS:  cfg.kernel_rows <= pwdata[3:0];
        apw_pkg::REG_KERNEL_COLS:  cfg.kernel_cols <= pwdata[3:0];
        apw_pkg::REG_STEP_ROWS:    cfg.step_rows <= pwdata[3:0];
        apw_pkg::REG_STEP_COLS:    cfg.step_cols <= pwdata[3:0];
        apw_pkg::REG_BORDER_ROWS:  cfg.border_rows <= pwdata[2:0];
        apw_pkg::REG_BORDER_COLS:  cfg.border_cols <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      apw_pkg::REG_PLANE_HEIGHT: prdata = apw_pkg::APB_DATA_W'(cfg.plane_height);
      apw_pkg::REG_PLANE_WIDTH:  prdata = apw_pkg::APB_DATA_W'(cfg.plane_width);
      apw_pkg::REG_KERNEL_ROWS:  prdata = apw_pkg::APB_DATA_W'(cfg.kernel_rows);
      apw_pkg::REG_KERNEL_COLS:  prdata = apw_pkg::APB_DATA_W'(cfg.kernel_cols);
      apw_pkg::REG_STEP_ROWS:    prdata = apw_pkg::APB_DATA_W'(cfg.step_rows);
      apw_pkg::REG_STEP_COLS:    prdata = apw_pkg::APB_DATA_W'(cfg.step_cols);
      apw_pkg::REG_BORDER_ROWS:  prdata = apw_pkg::APB_DATA_W'(cfg.border_rows);
      apw_pkg::REG_BORDER_COLS:  prdata = apw_pkg::APB_DATA_W'(cfg.border_cols);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller and datapath
  // ---------------------------------------------------------------------------
  apw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .out_free (out_free),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  apw_datapath #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .out_row (s_tdata[ROW_LO+apw_pkg::ROW_W-1:ROW_LO]),
    .out_col (s_tdata[COL_LO+apw_pkg::COL_W-1:COL_LO]),
    .status  (status),
    .average (result)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until taken, free it on the taking edge
  // ---------------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= result;
    end
  end

  assign m_tdata = OUT_W'($unsigned(average));

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while held");

  // reads in flight only during a query, never while taking beats
  assert property (@(posedge clk) disable iff (rst)
    status.pipe_busy |-> !s_tready)
    else $error("read pipeline busy while accepting beats");

  // controller issues at most one command per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.capture, cmd.issue, cmd.div_load, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule
